>>> hw/rtl/kslp_pkg.sv
// package with constants, types and helpers for the key press classifier
package kslp_pkg;

    localparam int KEY_COUNT = 4;
    localparam int LEVEL_W   = 4;
    localparam int TICK_W    = 32;
    localparam int EVT_W     = 4;

    localparam logic [TICK_W-1:0] LONG_PRESS_RESET = TICK_W'(500);
    localparam logic [EVT_W-1:0]  EVT_NONE         = '0;

    localparam int S_TDATA_W = ((LEVEL_W + TICK_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((EVT_W + 7) / 8) * 8;

    typedef enum logic {
        OP_POLL = 1'b0,
        OP_READ = 1'b1
    } t_opcode;

    typedef logic [KEY_COUNT-1:0] t_keys;

    function automatic logic [EVT_W-1:0] short_code(input int k);
        short_code = EVT_W'(2 * k + 1);
    endfunction

    function automatic logic [EVT_W-1:0] long_code(input int k);
        long_code = EVT_W'(2 * k + 2);
    endfunction

endpackage

>>> hw/rtl/key_short_long_press_classifier.sv
// top level: short/long press classifier for active-low keys
//
// one input stream carries poll and read beats; tuser selects the kind
// (0 poll with key levels and tick, 1 read and clear the latched event).
// a poll updates held flags, the shared press stamp and the latched event
// and gives no output beat. a read gives exactly one output beat holding
// the latched event code and clears it to zero.
// the long press threshold is loaded through i_cfg_we / i_cfg_wdata, by
// the user only while the block is idle (the block does not enforce this);
// reset sets it to 500 ticks. pipeline: input register, then compare and
// priority logic into the event state and the output register. a read
// beat passes from the input register to the output register for the
// receiver; one beat is taken every cycle except while a read waits.
// when the receiver stalls with a read result pending, a following poll
// still retires, while a following read waits in the input register and
// s_axis_tready drops until the output register drains.
// reset (synchronous, active low) clears held flags, the stamp, the
// latched event, both valid flags, and restores the threshold.
module key_short_long_press_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kslp_pkg::TICK_W-1:0]     i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // key_levels [3:0], now_tick [35:4], zero fill above
    input  logic [kslp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // opcode [0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // key_event [3:0], zero fill above
    output logic [kslp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import kslp_pkg::*;

    logic [TICK_W-1:0]   r_long_ticks;
    logic                r_in_valid;
    t_opcode             r_in_op;
    logic [LEVEL_W-1:0]  r_in_levels;
    logic [TICK_W-1:0]   r_in_tick;
    t_keys               r_held;
    logic [TICK_W-1:0]   r_stamp;
    logic [EVT_W-1:0]    r_latched;
    logic                r_out_valid;
    logic [EVT_W-1:0]    r_out_event;

    t_keys               pressed;
    t_keys               newly;
    t_keys               held_mid;
    t_keys               n_held;
    logic [TICK_W-1:0]   n_stamp;
    logic [TICK_W-1:0]   elapsed;
    logic                is_long;
    logic [EVT_W-1:0]    poll_event;
    logic [EVT_W-1:0]    n_latched;
    logic                advance;
    logic                read_go;

    assign advance = r_in_valid && ((r_in_op == OP_POLL) || !r_out_valid || m_axis_tready);
    assign read_go = advance && (r_in_op == OP_READ);

    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_event);

    // keys with no level bit read as released
    always_comb begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            pressed[k] = 1'b0;
            for (int j = 0; j < LEVEL_W; j++) begin
                if (j == k) begin
                    pressed[k] = ~r_in_levels[j];
                end
            end
        end
    end

    always_comb begin
        newly    = pressed & ~r_held;
        held_mid = r_held | newly;
        n_stamp  = (|newly) ? r_in_tick : r_stamp;
        elapsed  = r_in_tick - n_stamp;
        is_long  = elapsed > r_long_ticks;
        n_held   = held_mid & pressed;
        poll_event = r_latched;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (held_mid[k]) begin
                if (is_long) begin
                    poll_event = long_code(k);
                end else if (!pressed[k]) begin
                    poll_event = short_code(k);
                end
            end
        end
        n_latched = r_latched;
        if (advance) begin
            n_latched = (r_in_op == OP_READ) ? EVT_NONE : poll_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks <= LONG_PRESS_RESET;
            r_in_valid   <= 1'b0;
            r_held       <= '0;
            r_stamp      <= '0;
            r_latched    <= EVT_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_long_ticks <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance && (r_in_op == OP_POLL)) begin
                r_held  <= n_held;
                r_stamp <= n_stamp;
            end
            r_latched <= n_latched;
            if (read_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op     <= t_opcode'(s_axis_tuser);
            r_in_levels <= s_axis_tdata[LEVEL_W-1:0];
            r_in_tick   <= s_axis_tdata[LEVEL_W+TICK_W-1:LEVEL_W];
        end
        if (read_go) begin
            r_out_event <= r_latched;
        end
    end

    a_read_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        read_go |=> m_axis_tvalid)
        else $error("read did not produce an output beat");

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        read_go |=> (r_latched == EVT_NONE))
        else $error("latched event not cleared by read");

    a_poll_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !read_go) |=> !m_axis_tvalid)
        else $error("output beat without a read");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched <= EVT_W'(2 * KEY_COUNT))
        else $error("latched code out of range");

    a_no_read_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_in_op == OP_READ) && r_out_valid && !m_axis_tready)
            |-> !advance)
        else $error("read overwrote a pending result");

endmodule
